// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file slfr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/slfr_pkg.sv -----
// Types and constants of the sync-length frame receiver.
package slfr_pkg;

	localparam int WIN_DEPTH = 6;
	localparam int FILL_W    = 3;
	localparam int LEN_W     = 13;
	localparam int CNT_W     = 32;
	localparam int NUM_CLASS = 4;

	localparam logic [31:0]      SYNC_RESET = 32'hAA55CC33;
	localparam logic [LEN_W-1:0] LEN0_RESET = 13'd512;
	localparam logic [LEN_W-1:0] LEN1_RESET = 13'd1024;
	localparam logic [LEN_W-1:0] LEN2_RESET = 13'd2048;
	localparam logic [LEN_W-1:0] LEN3_RESET = 13'd4096;

	// Command byte codes that open a frame
	localparam logic [7:0] CMD_CLASS0 = 8'h01;
	localparam logic [7:0] CMD_CLASS1 = 8'h02;
	localparam logic [7:0] CMD_CLASS2 = 8'h03;
	localparam logic [7:0] CMD_CLASS3 = 8'h04;

	typedef enum logic [2:0] {
		CFG_SYNC_WORD = 3'd0,
		CFG_LEN0      = 3'd1,
		CFG_LEN1      = 3'd2,
		CFG_LEN2      = 3'd3,
		CFG_LEN3      = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_SYNC_ERR   = 2'd1,
		EV_CMD_SKIP   = 2'd2,
		EV_FRAME_DONE = 2'd3
	} event_t;

	typedef struct packed {
		event_t             event_res;
		logic [7:0]         ack_seq;
		logic [1:0]         size_class;
		logic [CNT_W-1:0]   class_frame_count;
		logic [CNT_W-1:0]   sync_error_count;
	} result_t;

endpackage

// ----- rtl/slfr_out_skid.sv -----
// Two-entry output buffer: result register plus skid register.
module slfr_out_skid
	import slfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    push;
	logic    pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			// advance the skid entry, or drain
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= in_data;
			end else begin
				skid_data_q <= in_data;
			end
		end else if (pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

endmodule

// ----- rtl/sync_length_frame_receiver.sv -----
// Sync-length frame receiver: hunt window, frame length counter and result stream.
//
// Takes one byte transaction per clock while s_axis_tready is high and returns exactly
// one result per transaction via the registered output buffer. All hunt-window compare,
// length lookup and counter updates happen in the accepting cycle, so the sustained rate
// is one item per cycle while results drain; a two-entry output buffer keeps the input
// side ready while one result waits downstream, and s_axis_tready drops only when both
// entries are held. Indexes above four are ignored. The user must write registers through
// cfg_we/cfg_index/cfg_wdata only while the stream is idle; the block does not enforce it.
module sync_length_frame_receiver
	import slfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // [7:0] ack_seq, [9:8] size_class,
	                                   // [41:10] class_frame_count,
	                                   // [73:42] sync_error_count, [79:74] zero
	output logic [1:0]  m_axis_tuser   // [1:0] event_res
);

	logic [31:0]      sync_word_q;
	logic [LEN_W-1:0] plen_q [NUM_CLASS];

	logic [7:0]        win_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic              in_frame_q;
	logic [LEN_W-1:0]  rem_q;
	logic [7:0]        seq_q;
	logic [1:0]        cls_q;
	logic [CNT_W-1:0]  cnt_q [NUM_CLASS];
	logic [CNT_W-1:0]  serr_q;

	logic [7:0]        win_d [WIN_DEPTH];
	logic [7:0]        win_wr [WIN_DEPTH];
	logic [FILL_W-1:0] fill_d;
	logic [FILL_W-1:0] fill_use;
	logic              in_frame_d;
	logic [LEN_W-1:0]  rem_d;
	logic [LEN_W-1:0]  rem_dec;
	logic [7:0]        seq_d;
	logic [1:0]        cls_d;
	logic [CNT_W-1:0]  cnt_d [NUM_CLASS];
	logic [CNT_W-1:0]  serr_d;

	logic [31:0]      head;
	logic [7:0]       cmd;
	logic             cmd_ok;
	logic [1:0]       cmd_cls;
	logic [LEN_W-1:0] len_sel;
	logic [LEN_W-1:0] len_clamp;
	logic             done;
	logic [1:0]       done_cls;
	logic [7:0]       done_seq;
	logic [CNT_W-1:0] cnt_inc;

	logic    push;
	logic    res_ready;
	result_t res_d;
	result_t res_out;

	assign push          = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = res_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_RESET;
			plen_q[0]   <= LEN0_RESET;
			plen_q[1]   <= LEN1_RESET;
			plen_q[2]   <= LEN2_RESET;
			plen_q[3]   <= LEN3_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_WORD: sync_word_q <= cfg_wdata;
				CFG_LEN0:      plen_q[0]   <= cfg_wdata[LEN_W-1:0];
				CFG_LEN1:      plen_q[1]   <= cfg_wdata[LEN_W-1:0];
				CFG_LEN2:      plen_q[2]   <= cfg_wdata[LEN_W-1:0];
				CFG_LEN3:      plen_q[3]   <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign fill_use = (fill_q >= FILL_W'(WIN_DEPTH)) ? FILL_W'(WIN_DEPTH - 1) : fill_q;
	assign head     = {win_q[0], win_q[1], win_q[2], win_q[3]};
	assign cmd      = win_q[4];
	assign cmd_cls  = 2'(cmd - 8'd1);
	assign len_sel  = plen_q[cmd_cls];
	assign len_clamp = (32'(len_sel) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len_sel;
	assign rem_dec  = (rem_q != '0) ? rem_q - LEN_W'(1) : '0;

	always_comb begin
		case (cmd)
			CMD_CLASS0, CMD_CLASS1, CMD_CLASS2, CMD_CLASS3: cmd_ok = 1'b1;
			default: cmd_ok = 1'b0;
		endcase
	end

	always_comb begin
		win_wr = win_q;
		win_wr[fill_use] = s_axis_tdata;

		win_d      = win_q;
		fill_d     = fill_q;
		in_frame_d = in_frame_q;
		rem_d      = rem_q;
		seq_d      = seq_q;
		cls_d      = cls_q;
		cnt_d      = cnt_q;
		serr_d     = serr_q;
		done       = 1'b0;
		done_cls   = cls_q;
		done_seq   = seq_q;
		res_d      = '0;
		res_d.event_res = EV_NONE;

		if (s_axis_tuser[0] == OP_RESTART) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_d[i] = '0;
			end
			fill_d     = '0;
			in_frame_d = 1'b0;
			rem_d      = '0;
			seq_d      = '0;
			cls_d      = '0;
			for (int i = 0; i < NUM_CLASS; i++) begin
				cnt_d[i] = '0;
			end
			serr_d = '0;
		end else if (in_frame_q) begin
			rem_d = rem_dec;
			if (rem_dec == '0) begin
				done = 1'b1;
			end
		end else if (fill_use == FILL_W'(WIN_DEPTH - 1)) begin
			// window full: inspect header
			if (head != sync_word_q || !cmd_ok) begin
				// drop oldest
				for (int i = 0; i < WIN_DEPTH - 1; i++) begin
					win_d[i] = win_wr[i + 1];
				end
				win_d[WIN_DEPTH-1] = '0;
				fill_d = FILL_W'(WIN_DEPTH - 1);
				if (head != sync_word_q) begin
					serr_d = serr_q + CNT_W'(1);
					res_d.event_res = EV_SYNC_ERR;
				end else begin
					res_d.event_res = EV_CMD_SKIP;
				end
			end else begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_d[i] = '0;
				end
				fill_d     = '0;
				in_frame_d = 1'b1;
				rem_d      = len_clamp;
				cls_d      = cmd_cls;
				seq_d      = s_axis_tdata;
				done_cls   = cmd_cls;
				done_seq   = s_axis_tdata;
				// zero length completes on the sequence byte
				if (len_clamp == '0) begin
					done = 1'b1;
				end
			end
		end else begin
			win_d  = win_wr;
			fill_d = fill_use + FILL_W'(1);
		end

		cnt_inc = cnt_q[done_cls] + CNT_W'(1);

		if (done) begin
			cnt_d[done_cls] = cnt_inc;
			in_frame_d      = 1'b0;
			rem_d           = '0;
			res_d.event_res         = EV_FRAME_DONE;
			res_d.ack_seq           = done_seq;
			res_d.size_class        = done_cls;
			res_d.class_frame_count = cnt_inc;
		end

		res_d.sync_error_count = serr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			rem_q      <= '0;
			seq_q      <= '0;
			cls_q      <= '0;
			for (int i = 0; i < NUM_CLASS; i++) begin
				cnt_q[i] <= '0;
			end
			serr_q <= '0;
		end else if (push) begin
			win_q      <= win_d;
			fill_q     <= fill_d;
			in_frame_q <= in_frame_d;
			rem_q      <= rem_d;
			seq_q      <= seq_d;
			cls_q      <= cls_d;
			cnt_q      <= cnt_d;
			serr_q     <= serr_d;
		end
	end

	slfr_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (res_ready),
		.in_data   (res_d),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res_out)
	);

	assign m_axis_tuser = res_out.event_res;
	assign m_axis_tdata = {6'b0, res_out.sync_error_count, res_out.class_frame_count,
		res_out.size_class, res_out.ack_seq};

endmodule

// ----- rtl/slfr_checker.sv -----
// Port-level checks of the sync-length frame receiver, bound to the top level.
`include "assert_macros.svh"

module slfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// stalled result holds
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// input side stalls only while a result is pending
	`ASSERT_SAME(a_ready_pending, clk, arst_n, !s_axis_tready, m_axis_tvalid, "not ready with empty output")

	// transaction into an empty output shows up in the next cycle
	`ASSERT_NEXT(a_latency, clk, arst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, m_axis_tvalid, "result missing one cycle after accept")

	// a taken result frees the skid entry
	`ASSERT_NEXT(a_ready_back, clk, arst_n, !s_axis_tready && m_axis_tready, s_axis_tready, "ready not restored after drain")

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (.*);
